// ===== rtl/lcg_shuffle_cbc_block_decrypt_top_macros.svh =====
// Assertion macros shared by the block decryptor's modules.
`ifndef LCG_SHUFFLE_CBC_BLOCK_DECRYPT_TOP_MACROS_SVH
`define LCG_SHUFFLE_CBC_BLOCK_DECRYPT_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define LSC_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define LSC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lsc_pkg.sv =====
// Types and constants of the block decryptor.
`default_nettype none
package lsc_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned BLOCK_W     = 8 * BLOCK_BYTES;

  // Byte generator: next = (109 * g + 57) mod 256.
  localparam logic [7:0] GEN_MUL = 8'd109;
  localparam logic [7:0] GEN_ADD = 8'd57;

  // Largest legal pad and the full block count.
  localparam logic [7:0] PAD_MAX    = 8'd16;
  localparam logic [4:0] FULL_COUNT = 5'd16;

  // Configuration register addresses.
  localparam logic [1:0] CFG_ADDR_SEED = 2'd0;

  typedef struct packed {
    logic [63:0] cipher_low;
    logic [63:0] cipher_high;
    logic        first_block;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] plain_low;
    logic [63:0] plain_high;
    logic [4:0]  byte_count;
    logic        bad_padding;
  } out_item_t;

  // A classified block as handed from the front queue to the engine.
  typedef struct packed {
    logic               needs_iv;
    logic               is_last;
    logic [BLOCK_W-1:0] cipher;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/lsc_front.sv =====
// Input queue that takes words and classifies them into engine jobs.
`default_nettype none
`include "lcg_shuffle_cbc_block_decrypt_top_macros.svh"
module lsc_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire lsc_pkg::in_item_t in_data,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output lsc_pkg::job_t         job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lsc_pkg::job_t    q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             enq, deq;
  lsc_pkg::job_t    job_in;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign job_valid = (cnt_r != '0);
  assign enq       = push && !full;
  assign deq       = job_valid && job_ready;
  assign job       = q_r[rd_ptr_r];

  always_comb begin
    job_in.needs_iv = in_data.first_block;
    job_in.is_last  = in_data.last_block;
    job_in.cipher   = {in_data.cipher_high, in_data.cipher_low};
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (deq && !enq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= job_in;
    end
  end

  `LSC_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue overfilled")
  `LSC_ASSERT_NEXT(a_full_holds, clk, rst_n, full && !deq, full, "full dropped without a dequeue")
  `LSC_ASSERT_NEXT(a_enq_grows, clk, rst_n, enq && !deq, cnt_r == $past(cnt_r) + 1'b1, "enqueue lost")

endmodule
`default_nettype wire

// ===== rtl/lsc_engine.sv =====
// Decryption engine: chaining vector, keystream, shuffle and result register.
`default_nettype none
`include "lcg_shuffle_cbc_block_decrypt_top_macros.svh"
module lsc_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        seed_byte,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire lsc_pkg::job_t     job,
  output logic                   empty,
  input  wire logic              pop,
  output lsc_pkg::out_item_t     out_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_IV   = 5'b00010,
    ST_KEY  = 5'b00100,
    ST_SHUF = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [3:0]                   cnt_r, cnt_nxt;
  logic [7:0]                   gen_r, gen_nxt;
  logic [lsc_pkg::BLOCK_W-1:0]  chain_r, chain_nxt;
  logic [lsc_pkg::BLOCK_W-1:0]  cipher_r;
  logic                         last_r;
  logic [7:0]                   p_r [lsc_pkg::BLOCK_BYTES];
  logic [7:0]                   k_r [lsc_pkg::BLOCK_BYTES];
  logic                         outv_r, outv_nxt;
  lsc_pkg::out_item_t           out_r;

  logic [15:0]                  prod;
  logic [7:0]                   draw;
  logic                         take, load;
  logic [3:0]                   idx_a, idx_b;
  logic [7:0]                   byte_a, byte_b;
  logic [lsc_pkg::BLOCK_W-1:0]  plain;
  logic [7:0]                   pad;
  lsc_pkg::out_item_t           res;

  // One generator step per cycle.
  assign prod = 16'(lsc_pkg::GEN_MUL) * 16'(gen_r);
  assign draw = prod[7:0] + lsc_pkg::GEN_ADD;

  assign job_ready = (state_r == ST_IDLE);
  assign take      = job_valid && job_ready;
  assign load      = (state_r == ST_DONE) && (!outv_r || pop);
  assign empty     = !outv_r;
  assign out_data  = out_r;

  // The swaps run from byte 15 down, so the latest unused keystream byte sits in k_r[0].
  assign idx_a  = k_r[0][3:0];
  assign idx_b  = k_r[0][7:4];
  assign byte_a = p_r[idx_a];
  assign byte_b = p_r[idx_b];

  always_comb begin
    for (int j = 0; j < lsc_pkg::BLOCK_BYTES; j++) begin
      plain[8*j +: 8] = p_r[j] ^ chain_r[8*j +: 8];
    end
    pad             = plain[lsc_pkg::BLOCK_W-1 -: 8];
    res.plain_low   = plain[63:0];
    res.plain_high  = plain[127:64];
    res.byte_count  = lsc_pkg::FULL_COUNT;
    res.bad_padding = 1'b0;
    if (last_r) begin
      if (pad > lsc_pkg::PAD_MAX) begin
        res.bad_padding = 1'b1;
      end else begin
        res.byte_count = lsc_pkg::FULL_COUNT - pad[4:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    gen_nxt   = gen_r;
    chain_nxt = chain_r;
    outv_nxt  = outv_r;
    if (outv_r && pop) begin
      outv_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          cnt_nxt = '0;
          if (job.needs_iv) begin
            gen_nxt   = seed_byte;
            state_nxt = ST_IV;
          end else begin
            state_nxt = ST_KEY;
          end
        end
      end
      ST_IV: begin
        gen_nxt                 = draw;
        chain_nxt[8*cnt_r +: 8] = draw;
        cnt_nxt                 = cnt_r + 1'b1;
        if (cnt_r == 4'hf) begin
          state_nxt = ST_KEY;
        end
      end
      ST_KEY: begin
        gen_nxt = draw;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'hf) begin
          state_nxt = ST_SHUF;
        end
      end
      ST_SHUF: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'hf) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          outv_nxt  = 1'b1;
          chain_nxt = cipher_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      gen_r   <= '0;
      chain_r <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      gen_r   <= gen_nxt;
      chain_r <= chain_nxt;
      outv_r  <= outv_nxt;
    end
  end

  // Block datapath: ciphertext load, keystream XOR, the swap network and the result load.
  always_ff @(posedge clk) begin
    if (take) begin
      cipher_r <= job.cipher;
      last_r   <= job.is_last;
      for (int j = 0; j < lsc_pkg::BLOCK_BYTES; j++) begin
        p_r[j] <= job.cipher[8*j +: 8];
      end
    end
    if (state_r == ST_KEY) begin
      p_r[cnt_r] <= p_r[cnt_r] ^ draw;
      k_r[0]     <= draw;
      for (int j = 1; j < lsc_pkg::BLOCK_BYTES; j++) begin
        k_r[j] <= k_r[j-1];
      end
    end
    if (state_r == ST_SHUF) begin
      for (int j = 0; j < lsc_pkg::BLOCK_BYTES; j++) begin
        if (4'(j) == idx_a) begin
          p_r[j] <= byte_b;
        end else if (4'(j) == idx_b) begin
          p_r[j] <= byte_a;
        end
      end
      for (int j = 0; j < lsc_pkg::BLOCK_BYTES - 1; j++) begin
        k_r[j] <= k_r[j+1];
      end
    end
    if (load) begin
      out_r <= res;
    end
  end

  `LSC_ASSERT_NEXT(a_iv_first, clk, rst_n, take && job.needs_iv, state_r == ST_IV,
                   "first block skipped vector derivation")
  `LSC_ASSERT_NEXT(a_key_to_shuf, clk, rst_n, state_r == ST_KEY && cnt_r == 4'hf,
                   state_r == ST_SHUF, "keystream did not end in shuffle")
  `LSC_ASSERT_NEXT(a_chain_steady, clk, rst_n, state_r == ST_SHUF, $stable(chain_r),
                   "chaining vector moved during shuffle")

endmodule
`default_nettype wire

// ===== rtl/lcg_shuffle_cbc_block_decrypt_top.sv =====
// Top level of the shuffle and chaining block decryptor.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------
//   input    | push / full              | in_data  (lsc_pkg::in_item_t)
//   result   | empty / pop              | out_data (lsc_pkg::out_item_t)
//   config   | psel/penable/pwrite/...  | seed_byte at byte address 0
//
// The engine takes no new block until it is through with the last: it accepts
// a block, makes 16 keystream draws, does 16 swaps and finishes it; a first
// block's chaining vector costs 16 more generator draws before the keystream,
// with a single generator step per cycle.
// Reset is synchronous and active low and clears all control state at once.
// The input queue takes words until full while the engine works, and a finished
// word waits in the result register; only a second finished word stalls the engine.
`default_nettype none
module lcg_shuffle_cbc_block_decrypt_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire lsc_pkg::in_item_t  in_data,
  output logic                    empty,
  input  wire logic               pop,
  output lsc_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [7:0]    seed_r, seed_nxt;
  logic          job_valid;
  logic          job_ready;
  lsc_pkg::job_t job;

  assign pready = 1'b1;
  assign prdata = (paddr == lsc_pkg::CFG_ADDR_SEED) ? {24'b0, seed_r} : 32'b0;

  always_comb begin
    seed_nxt = seed_r;
    if (psel && penable && pwrite && pready && (paddr == lsc_pkg::CFG_ADDR_SEED)) begin
      seed_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  lsc_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  lsc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed_byte (seed_r),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the shuffle and chaining block decryptor, with its own predictor.
module testbench;

  // Sixteen bytes, byte 0 in bits 7:0.
  typedef logic [15:0][7:0] block_t;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  class block_decrypt_predictor;
    logic [7:0]          seed;
    logic [7:0]          gen;
    block_t              chain;
    lsc_pkg::out_item_t  plain_due[$];
    int                  faults;

    function new();
      seed = '0;
      gen = '0;
      chain = '0;
      faults = 0;
    endfunction

    // Chaining vector and keystream that a word will use, without touching the state.
    function void derive(input lsc_pkg::in_item_t it, output block_t iv, output block_t ks,
                         output logic [7:0] g_next);
      logic [7:0] g;
      g = gen;
      iv = chain;
      if (it.first_block) begin
        g = seed;
        for (int i = 0; i < 16; i++) begin
          g = lsc_pkg::GEN_MUL * g + lsc_pkg::GEN_ADD;
          iv[i] = g;
        end
      end
      for (int i = 0; i < 16; i++) begin
        g = lsc_pkg::GEN_MUL * g + lsc_pkg::GEN_ADD;
        ks[i] = g;
      end
      g_next = g;
    endfunction

    // Rewrites one ciphertext byte so that plaintext byte 15 comes out as the given pad.
    function lsc_pkg::in_item_t with_pad(lsc_pkg::in_item_t it, logic [7:0] pad);
      block_t     iv, ks, ct;
      logic [7:0] g_next;
      logic [3:0] src [16];
      logic [3:0] t;
      derive(it, iv, ks, g_next);
      for (int i = 0; i < 16; i++) src[i] = 4'(i);
      for (int i = 15; i >= 0; i--) begin
        t = src[ks[i][3:0]];
        src[ks[i][3:0]] = src[ks[i][7:4]];
        src[ks[i][7:4]] = t;
      end
      ct = {it.cipher_high, it.cipher_low};
      ct[src[15]] = pad ^ ks[src[15]] ^ iv[15];
      it.cipher_low = ct[7:0];
      it.cipher_high = ct[15:8];
      return it;
    endfunction

    function void note_block(lsc_pkg::in_item_t it);
      block_t              iv, ks, ct, pt;
      logic [7:0]          g_next, t, pad;
      lsc_pkg::out_item_t  r;
      derive(it, iv, ks, g_next);
      ct = {it.cipher_high, it.cipher_low};
      pt = ct ^ ks;
      for (int i = 15; i >= 0; i--) begin
        t = pt[ks[i][3:0]];
        pt[ks[i][3:0]] = pt[ks[i][7:4]];
        pt[ks[i][7:4]] = t;
      end
      pt = pt ^ iv;
      chain = ct;
      gen = g_next;
      r.plain_low = pt[7:0];
      r.plain_high = pt[15:8];
      r.byte_count = lsc_pkg::FULL_COUNT;
      r.bad_padding = 1'b0;
      if (it.last_block) begin
        pad = pt[15];
        if (pad > lsc_pkg::PAD_MAX) r.bad_padding = 1'b1;
        else r.byte_count = lsc_pkg::FULL_COUNT - pad[4:0];
      end
      plain_due.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
        faults++;
      end
    endfunction

    function void check_plain(lsc_pkg::out_item_t got);
      lsc_pkg::out_item_t want;
      if (plain_due.size() == 0) begin
        $display("%0t: word expected none, got %h", $time, got);
        faults++;
      end else begin
        want = plain_due.pop_front();
        compare("plain_low", want.plain_low, got.plain_low);
        compare("plain_high", want.plain_high, got.plain_high);
        compare("byte_count", 64'(want.byte_count), 64'(got.byte_count));
        compare("bad_padding", 64'(want.bad_padding), 64'(got.bad_padding));
      end
    endfunction
  endclass

  logic               clk, rst_n;
  logic               push, full, empty, pop;
  lsc_pkg::in_item_t  in_data;
  lsc_pkg::out_item_t out_data;
  logic               psel, penable, pwrite, pready;
  logic [1:0]         paddr;
  logic [31:0]        pwdata, prdata;

  block_decrypt_predictor decrypt_model;
  bit tx_burst, rx_burst, rx_hold;
  int quiet_cycles = 0;

  lcg_shuffle_cbc_block_decrypt_top dut (
    .clk, .rst_n, .push, .full, .in_data, .empty, .pop, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && push && !full) decrypt_model.note_block(in_data);
    if (rst_n && pop && !empty) decrypt_model.check_plain(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: a random stall before each word unless in burst, and one long hold when asked.
  initial begin
    int stall;
    pop = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        rx_hold = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = rx_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic lsc_pkg::in_item_t make_block(logic [63:0] lo, logic [63:0] hi,
                                                   bit first, bit last);
    lsc_pkg::in_item_t it;
    it.cipher_low = lo;
    it.cipher_high = hi;
    it.first_block = first;
    it.last_block = last;
    return it;
  endfunction

  function automatic logic [7:0] pick_pad();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(17, 255));
    return 8'($urandom_range(0, 16));
  endfunction

  // Called and left at a falling edge; push stays high when the next word follows at once.
  task automatic send_block(lsc_pkg::in_item_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (decrypt_model.plain_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_seed(logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lsc_pkg::CFG_ADDR_SEED;
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    decrypt_model.seed = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // The pad is fixed only once every earlier word has gone into the predictor.
  task automatic send_message(int blocks);
    lsc_pkg::in_item_t it;
    for (int b = 0; b < blocks; b++) begin
      it = make_block(rand64(), rand64(), b == 0, b == blocks - 1);
      if (it.last_block) it = decrypt_model.with_pad(it, pick_pad());
      send_block(it);
    end
  endtask

  task automatic random_phase(logic [7:0] seed, int words);
    int sent, len;
    write_seed(seed);
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 6) == 0) begin
        send_block(make_block(rand64(), rand64(), 1'($urandom), 1'($urandom)));
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        send_message(len);
        sent += len;
      end
    end
    wait_drained();
  endtask

  initial begin
    decrypt_model = new();
    push = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    rx_hold = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Before any first block the generator and chaining vector run from zero.
    send_block(make_block(64'd0, 64'd0, 1'b0, 1'b0));
    send_block(make_block('1, '1, 1'b0, 1'b0));
    send_block(decrypt_model.with_pad(
      make_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0, 1'b1), 8'd0));
    send_block(decrypt_model.with_pad(make_block(rand64(), rand64(), 1'b1, 1'b1), 8'd16));
    send_block(decrypt_model.with_pad(
      make_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b1), 8'd17));
    send_block(make_block(rand64(), rand64(), 1'b1, 1'b0));
    send_block(make_block(rand64(), rand64(), 1'b0, 1'b0));
    send_block(decrypt_model.with_pad(make_block(rand64(), rand64(), 1'b0, 1'b1), 8'd255));
    send_block(decrypt_model.with_pad(make_block(rand64(), rand64(), 1'b0, 1'b1), 8'd1));
    wait_drained();
    write_seed(8'hff);
    send_block(decrypt_model.with_pad(make_block('1, 64'd0, 1'b1, 1'b1), 8'd15));
    send_block(make_block(64'd0, '1, 1'b1, 1'b0));
    send_block(decrypt_model.with_pad(make_block(rand64(), rand64(), 1'b0, 1'b1), 8'd128));
    send_block(decrypt_model.with_pad(make_block(rand64(), rand64(), 1'b1, 1'b1), 8'd8));
    wait_drained();

    // The receiver holds off early on, so the queue fills and push is refused for a while.
    rx_hold = 1'b1;
    random_phase(8'h00, 75);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    random_phase(8'($urandom), 75);
    rx_burst = 1'b0;
    random_phase(8'h80, 75);
    tx_burst = 1'b0;
    rx_burst = 1'b1;
    random_phase(8'($urandom), 75);
    rx_burst = 1'b0;
    random_phase(8'h01, 75);
    random_phase(8'($urandom), 75);

    repeat (60) @(negedge clk);
    if (decrypt_model.faults == 0 && decrypt_model.plain_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
